// ----- hdl/phb_pkg.sv -----
`timescale 1ns / 1ps

package phb_pkg;

    // Field and register widths
    localparam int MODE_W  = 2;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 9;
    localparam int CNT_W   = 25;
    localparam int PROD_W  = PIX_W + CFG_W;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ACC      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_CLR = 2'd2;

    // Counter saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Bin-count register reset value
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Pixel full-scale divisor
    localparam logic [PROD_W-1:0] PIX_SCALE = 17'd255;

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    typedef logic [MODE_W-1:0] t_mode;

endpackage

// ----- hdl/pixel_histogram_binning.sv -----
`timescale 1ns / 1ps
// A read result passes stage 1 and stage 2 and is offered from the result queue.
// Throughput: one item per cycle while not stalled; the counter memory is read in
// one stage and written back in the next, with a one-entry write-back bypass for
// same-bin hits. The input stalls while 4 read results are queued or in flight.
// Reset: synchronous; afterwards a clearing pass zeroes the bin memory, one
// entry a cycle, through all MAX_BINS entries, during which no item is accepted.
module pixel_histogram_binning #(
    parameter int MAX_BINS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [phb_pkg::MODE_W-1:0]     i_mode,
    input  logic [phb_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic [phb_pkg::IDX_W-1:0]      i_bin_index,
    // bin-count register
    input  logic                           i_cfg_we,
    input  logic [phb_pkg::CFG_W-1:0]      i_cfg_data,
    // result items
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [phb_pkg::CNT_W-1:0]      o_bin_total,
    output logic                           o_index_invalid
);
    import phb_pkg::*;

    localparam int AW       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NMAX_INT = (MAX_BINS < 511) ? MAX_BINS : 511;
    localparam logic [CFG_W-1:0] NMAX = CFG_W'(NMAX_INT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

    // ---------------------------------------------------------------
    // Configuration and bins in use
    logic [CFG_W-1:0] r_bin_count;
    logic [CFG_W-1:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_bin_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_bin_count == '0) begin
            w_n = CFG_W'(1);
        end else if (r_bin_count > NMAX) begin
            w_n = NMAX;
        end else begin
            w_n = r_bin_count;
        end
    end

    // ---------------------------------------------------------------
    // Clearing pass after reset
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Accept stage: pixel * bins, read-index check
    logic w_in_acc;
    logic w_mode_ok;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_mode_ok = (i_mode == MODE_ACC) || (i_mode == MODE_READ) ||
                       (i_mode == MODE_READ_CLR);

    logic              r_s1_vld;
    t_mode             r_s1_mode;
    logic [PROD_W-1:0] r_s1_prod;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s1_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_in_acc && w_mode_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mode <= i_mode;
            r_s1_prod <= PROD_W'(i_pixel_value) * PROD_W'(w_n);
            r_s1_idx  <= i_bin_index;
            r_s1_inv  <= {1'b0, i_bin_index} >= w_n;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: divide by 255 (reciprocal 257/65536 plus one correction),
    // clamp, memory read address
    logic [CNT_W-1:0]  w_x257;
    logic [CFG_W-1:0]  w_q0;
    logic [PROD_W-1:0] w_rem;
    logic [CFG_W-1:0]  w_q;
    logic [CFG_W-1:0]  w_bin;
    logic [AW-1:0]     w_s1_addr;

    assign w_x257 = CNT_W'(r_s1_prod) + {r_s1_prod, 8'd0};
    assign w_q0   = w_x257[CNT_W-1:16];
    assign w_rem  = r_s1_prod - {w_q0, 8'd0} + PROD_W'(w_q0);
    assign w_q    = w_q0 + CFG_W'(w_rem >= PIX_SCALE);
    // pixel 255 would land one past the last bin
    assign w_bin  = (w_q >= w_n) ? (w_n - CFG_W'(1)) : w_q;
    assign w_s1_addr = (r_s1_mode == MODE_ACC) ? AW'(w_bin) : AW'(r_s1_idx);

    logic          r_s2_vld;
    t_mode         r_s2_mode;
    logic [AW-1:0] r_s2_addr;
    logic          r_s2_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mode <= r_s1_mode;
        r_s2_addr <= w_s1_addr;
        r_s2_inv  <= r_s1_inv && (r_s1_mode != MODE_ACC);
    end

    // ---------------------------------------------------------------
    // Bin counter memory
    logic [CNT_W-1:0] r_mem [MAX_BINS];
    logic [CNT_W-1:0] r_rd_data;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [CNT_W-1:0] w_mem_wdata;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_s1_addr];
    end

    // ---------------------------------------------------------------
    // Stage 2: bypass, modify, write back
    logic             r_s3_vld;
    logic [AW-1:0]    r_s3_addr;
    logic [CNT_W-1:0] r_s3_data;
    logic [CNT_W-1:0] w_old;
    logic [CNT_W-1:0] w_new;
    logic             w_s2_we;
    logic             w_s2_rd;

    // previous write landed on the same edge as this read
    assign w_old = (r_s3_vld && (r_s3_addr == r_s2_addr)) ? r_s3_data : r_rd_data;

    always_comb begin
        w_new   = w_old;
        w_s2_we = 1'b0;
        w_s2_rd = 1'b0;
        unique case (r_s2_mode)
            MODE_ACC: begin
                w_s2_we = r_s2_vld;
                if (w_old != CNT_MAX) begin
                    w_new = w_old + CNT_W'(1);
                end
            end
            MODE_READ: begin
                w_s2_rd = r_s2_vld;
            end
            MODE_READ_CLR: begin
                w_s2_rd = r_s2_vld;
                w_s2_we = r_s2_vld && !r_s2_inv;
                w_new   = '0;
            end
            default: begin
                w_new = w_old;
            end
        endcase
    end

    assign w_mem_we    = i_rst_n && (r_clearing || w_s2_we);
    assign w_mem_waddr = r_clearing ? r_clr_addr : r_s2_addr;
    assign w_mem_wdata = r_clearing ? '0 : w_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= w_s2_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_addr <= r_s2_addr;
        r_s3_data <= w_new;
    end

    // ---------------------------------------------------------------
    // Result queue
    logic [CNT_W-1:0]     r_res_total [RES_DEPTH];
    logic                 r_res_inv   [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_CNT_W-1:0] r_res_cnt;
    logic                 w_push;
    logic                 w_pop;
    logic [RES_CNT_W-1:0] w_pending;
    logic                 w_s1_rd;

    assign w_push = w_s2_rd;
    assign w_pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_res_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + RES_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_res_cnt <= r_res_cnt + RES_CNT_W'(w_push) - RES_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_res_total[r_wr_ptr] <= r_s2_inv ? '0 : w_old;
            r_res_inv[r_wr_ptr]   <= r_s2_inv;
        end
    end

    assign o_valid         = r_res_cnt != '0;
    assign o_bin_total     = r_res_total[r_rd_ptr];
    assign o_index_invalid = r_res_inv[r_rd_ptr];

    // stall when queued plus in-flight reads could overrun the queue
    assign w_s1_rd   = r_s1_vld && (r_s1_mode != MODE_ACC);
    assign w_pending = r_res_cnt + RES_CNT_W'(w_s1_rd) + RES_CNT_W'(w_s2_rd);
    assign o_stall   = r_clearing || (w_pending >= RES_CNT_W'(RES_DEPTH));

    // ---------------------------------------------------------------
    // Assertions
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pending <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overcommitted");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_vld && !r_s2_vld && !r_s3_vld))
        else $error("item in flight during clearing pass");

    a_bypass_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_we |=> (r_s3_vld && (r_s3_addr == $past(r_s2_addr))))
        else $error("write-back bypass lost a write");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_invalid) |-> (o_bin_total == '0))
        else $error("invalid read carries a count");

    a_no_clear_on_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_inv) |-> !w_s2_we)
        else $error("invalid read wrote the memory");

endmodule
